// File: hw/rtl/shmt_pkg.sv
// Types, index tables and codes shared by the Hessian transform core.
`timescale 1ns / 1ps
`default_nettype none

package shmt_pkg;

  localparam int unsigned MAP_ROWS  = 3;
  localparam int unsigned MAP_COLS  = 3;
  localparam int unsigned MAP_WORDS = MAP_ROWS * MAP_COLS;
  localparam int unsigned OUT_COUNT = 6;
  localparam int unsigned STAGES    = 5;

  localparam int unsigned S_TDATA_W = 296;
  localparam int unsigned M_TDATA_W = 192;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  localparam logic [1:0] ROW_XI   = 2'd0;
  localparam logic [1:0] ROW_ETA  = 2'd1;
  localparam logic [1:0] ROW_ZETA = 2'd2;

  localparam logic [1:0] DIM_RESET = 2'd3;

  localparam int unsigned POS_I [OUT_COUNT] = '{0, 0, 0, 1, 1, 2};
  localparam int unsigned POS_J [OUT_COUNT] = '{0, 1, 2, 1, 2, 2};

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] dword_t;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  typedef word_t map_t [MAP_WORDS];
  typedef word_t sym_t [MAP_WORDS];
  typedef word_t col_t [MAP_ROWS];

  typedef struct packed {
    logic       en;
    logic [1:0] row;
    word_t      dx;
    word_t      dy;
    word_t      dz;
  } map_wr_t;

  typedef struct packed {
    logic       adv;
    logic [1:0] dim;
  } lane_ctrl_t;

  typedef struct packed {
    word_t val;
    logic  sat;
  } lane_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/shmt_map_store.sv
// Register file for the inverse mapping Jacobian, written one row per load item.
`timescale 1ns / 1ps
`default_nettype none

module shmt_map_store import shmt_pkg::*; (
  input  wire     clk_i,
  input  map_wr_t wr_i,
  output map_t    map_o
);

  word_t map_q [MAP_WORDS];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      unique case (wr_i.row)
        ROW_XI: begin
          map_q[0] <= wr_i.dx;
          map_q[1] <= wr_i.dy;
          map_q[2] <= wr_i.dz;
        end
        ROW_ETA: begin
          map_q[3] <= wr_i.dx;
          map_q[4] <= wr_i.dy;
          map_q[5] <= wr_i.dz;
        end
        ROW_ZETA: begin
          map_q[6] <= wr_i.dx;
          map_q[7] <= wr_i.dy;
          map_q[8] <= wr_i.dz;
        end
        default: begin
        end
      endcase
    end
  end

  assign map_o = map_q;

endmodule

`default_nettype wire

// File: hw/rtl/shmt_lane.sv
// One output lane: map products, rounding, Hessian terms, adder tree and saturation.
`timescale 1ns / 1ps
`default_nettype none

module shmt_lane import shmt_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire        clk_i,
  input  lane_ctrl_t ctrl_i,
  input  col_t       col_i_i,
  input  col_t       col_j_i,
  input  sym_t       hess_i,
  output lane_res_t  res_o
);

  localparam int unsigned PSUM_W = 66;
  localparam int unsigned SUM_W  = 68;

  localparam dword_t HALF_P = dword_t'(1) <<< (FRAC_BITS - 1);
  localparam dword_t P_MAX  = dword_t'(WORD_MAX);
  localparam dword_t P_MIN  = dword_t'(WORD_MIN);
  localparam logic signed [SUM_W-1:0] HALF_S = SUM_W'(HALF_P);
  localparam logic signed [SUM_W-1:0] S_MAX  = SUM_W'(P_MAX);
  localparam logic signed [SUM_W-1:0] S_MIN  = SUM_W'(P_MIN);

  dword_t     prod_d [MAP_WORDS];
  dword_t     prod_q [MAP_WORDS];
  word_t      h1_q   [MAP_WORDS];
  logic [1:0] dim1_q;

  word_t      p_d    [MAP_WORDS];
  word_t      p_q    [MAP_WORDS];
  word_t      h2_q   [MAP_WORDS];
  logic       f2_d;
  logic       f2_q;

  dword_t     term_d [MAP_WORDS];
  dword_t     term_q [MAP_WORDS];
  logic       f3_q;

  logic signed [PSUM_W-1:0] part_d [MAP_ROWS];
  logic signed [PSUM_W-1:0] part_q [MAP_ROWS];
  logic                     f4_q;

  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SUM_W-1:0]  sum_q;
  logic                     f5_q;

  always_comb begin
    for (int k = 0; k < MAP_ROWS; k++) begin
      for (int l = 0; l < MAP_ROWS; l++) begin
        prod_d[k*MAP_ROWS + l] = dword_t'(col_i_i[k]) * dword_t'(col_j_i[l]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      prod_q <= prod_d;
      h1_q   <= hess_i;
      dim1_q <= ctrl_i.dim;
    end
  end

  always_comb begin
    dword_t rnd;
    dword_t shr;
    logic   used;
    f2_d = 1'b0;
    for (int k = 0; k < MAP_ROWS; k++) begin
      for (int l = 0; l < MAP_ROWS; l++) begin
        rnd  = prod_q[k*MAP_ROWS + l] + HALF_P;
        shr  = rnd >>> FRAC_BITS;
        used = (2'(k) < dim1_q) && (2'(l) < dim1_q);
        if (!used) begin
          p_d[k*MAP_ROWS + l] = '0;
        end else if (shr > P_MAX) begin
          p_d[k*MAP_ROWS + l] = WORD_MAX;
          f2_d = 1'b1;
        end else if (shr < P_MIN) begin
          p_d[k*MAP_ROWS + l] = WORD_MIN;
          f2_d = 1'b1;
        end else begin
          p_d[k*MAP_ROWS + l] = shr[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      p_q  <= p_d;
      h2_q <= h1_q;
      f2_q <= f2_d;
    end
  end

  always_comb begin
    for (int n = 0; n < MAP_WORDS; n++) begin
      term_d[n] = dword_t'(p_q[n]) * dword_t'(h2_q[n]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      term_q <= term_d;
      f3_q   <= f2_q;
    end
  end

  always_comb begin
    for (int g = 0; g < MAP_ROWS; g++) begin
      part_d[g] = PSUM_W'(term_q[g*MAP_ROWS]) + PSUM_W'(term_q[g*MAP_ROWS + 1])
                + PSUM_W'(term_q[g*MAP_ROWS + 2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      part_q <= part_d;
      f4_q   <= f3_q;
    end
  end

  assign sum_d = SUM_W'(part_q[0]) + SUM_W'(part_q[1]) + SUM_W'(part_q[2]) + HALF_S;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      sum_q <= sum_d;
      f5_q  <= f4_q;
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] shs;
    shs = sum_q >>> FRAC_BITS;
    if (shs > S_MAX) begin
      res_o.val = WORD_MAX;
      res_o.sat = 1'b1;
    end else if (shs < S_MIN) begin
      res_o.val = WORD_MIN;
      res_o.sat = 1'b1;
    end else begin
      res_o.val = shs[31:0];
      res_o.sat = f5_q;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/shape_hessian_map_transform_core.sv
// Top level of the Hessian reference-to-physical transform core.
//
//  channel  | dir | handshake              | contents
//  s_axis   | in  | s_axis_tvalid/tready   | load row or Hessian, tuser = op
//  m_axis   | out | m_axis_tvalid/tready   | six physical entries, tuser = saturated
//  cfg      | in  | cfg_we_i               | element_dim
//
// One item per cycle while m_axis does not stall; a transform result passes through
// the five lane stages (two 32x32 multiplies, a rounding stage, two adder
// levels) and then the output register. Load items produce no result and update the map at accept.
// Reset clears valid bits and sets element_dim to 3; map rows are undefined until loaded.
// While a result waits on m_axis_tready, the whole pipeline and s_axis_tready hold.
`timescale 1ns / 1ps
`default_nettype none

module shape_hessian_map_transform_core import shmt_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  // map_row, row_dx, row_dy, row_dz, h_xi_xi, h_xi_eta, h_eta_eta,
  // h_xi_zeta, h_eta_zeta, h_zeta_zeta, zero fill
  input  wire  [S_TDATA_W-1:0] s_axis_tdata,
  // op
  input  wire                  s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  // out_xx, out_xy, out_xz, out_yy, out_yz, out_zz
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // saturated
  output logic                 m_axis_tuser,
  input  wire                  cfg_we_i,
  input  wire  [1:0]           cfg_wdata_i
);

  logic              adv;
  logic              acc;
  logic [1:0]        dim_q;
  logic [STAGES-1:0] vld_q;
  logic              ov_q;
  word_t             res_q [OUT_COUNT];
  logic              sat_q;
  logic              any_sat;

  map_wr_t    map_wr;
  map_t       map_w;
  sym_t       hsym;
  lane_ctrl_t lane_ctrl;
  lane_res_t  lane_res [OUT_COUNT];

  assign adv           = !ov_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      dim_q <= cfg_wdata_i;
    end
  end

  assign map_wr.en  = acc && (s_axis_tuser == OP_LOAD);
  assign map_wr.row = s_axis_tdata[1:0];
  assign map_wr.dx  = s_axis_tdata[33:2];
  assign map_wr.dy  = s_axis_tdata[65:34];
  assign map_wr.dz  = s_axis_tdata[97:66];

  shmt_map_store u_map_store (
    .clk_i (clk_i),
    .wr_i  (map_wr),
    .map_o (map_w)
  );

  assign hsym[0] = s_axis_tdata[129:98];
  assign hsym[1] = s_axis_tdata[161:130];
  assign hsym[2] = s_axis_tdata[225:194];
  assign hsym[3] = s_axis_tdata[161:130];
  assign hsym[4] = s_axis_tdata[193:162];
  assign hsym[5] = s_axis_tdata[257:226];
  assign hsym[6] = s_axis_tdata[225:194];
  assign hsym[7] = s_axis_tdata[257:226];
  assign hsym[8] = s_axis_tdata[289:258];

  assign lane_ctrl.adv = adv;
  assign lane_ctrl.dim = dim_q;

  for (genvar r = 0; r < OUT_COUNT; r++) begin : g_lane
    col_t col_i;
    col_t col_j;
    for (genvar k = 0; k < MAP_ROWS; k++) begin : g_col
      assign col_i[k] = map_w[k*MAP_COLS + POS_I[r]];
      assign col_j[k] = map_w[k*MAP_COLS + POS_J[r]];
    end
    shmt_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (lane_ctrl),
      .col_i_i (col_i),
      .col_j_i (col_j),
      .hess_i  (hsym),
      .res_o   (lane_res[r])
    );
  end

  always_comb begin
    any_sat = 1'b0;
    for (int r = 0; r < OUT_COUNT; r++) begin
      any_sat = any_sat | lane_res[r].sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ov_q  <= 1'b0;
    end else if (adv) begin
      vld_q <= {vld_q[STAGES-2:0], acc && (s_axis_tuser == OP_XFORM)};
      ov_q  <= vld_q[STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < OUT_COUNT; r++) begin
        res_q[r] <= lane_res[r].val;
      end
      sat_q <= any_sat;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {res_q[5], res_q[4], res_q[3], res_q[2], res_q[1], res_q[0]};
  assign m_axis_tuser  = sat_q;

`ifndef SYNTH
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (s_axis_tuser == OP_LOAD)) |=> !vld_q[0])
    else $error("load item entered the result pipeline");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld_q[STAGES-1]) |=> m_axis_tvalid)
    else $error("finished item did not reach the output register");
`endif

endmodule

`default_nettype wire

// File: tb/sv/shape_hessian_map_transform_core_test.sv
// Self-checking testbench for the Hessian reference-to-physical transform core.
`timescale 1ns / 1ps

module shape_hessian_map_transform_core_test;
  import shmt_pkg::*;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned PHASE_ITEMS = 350;

  localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [127:0] WIDE_MAX = 128'sd2147483647;
  localparam logic signed [127:0] WIDE_MIN = -128'sd2147483648;
  localparam word_t ONE = 32'sh0001_0000;

  typedef logic [OUT_COUNT-1:0][31:0] hess_vec_t;

  typedef struct packed {
    hess_vec_t v;
    logic      sat;
  } hess_out_t;

  typedef enum int unsigned {
    SPREAD_FULL,
    SPREAD_UNIT,
    SPREAD_WIDE,
    SPREAD_EDGE
  } spread_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = OP_LOAD;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_we_i = 1'b0;
  logic [1:0]           cfg_wdata_i = '0;

  word_t       inv_map [MAP_ROWS][MAP_COLS];
  logic [1:0]  dim_model = DIM_RESET;
  hess_out_t   pending_hessians [$];
  int unsigned error_count = 0;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;

  string FIELD_NAMES [OUT_COUNT] = '{"out_xx", "out_xy", "out_xz", "out_yy", "out_yz", "out_zz"};

  shape_hessian_map_transform_core #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic word_t clip_word(input logic signed [127:0] v, inout logic sat);
    if (v > WIDE_MAX) begin
      sat = 1'b1;
      return WORD_MAX;
    end
    if (v < WIDE_MIN) begin
      sat = 1'b1;
      return WORD_MIN;
    end
    return v[31:0];
  endfunction

  function automatic hess_out_t physical_hessian(input hess_vec_t hs);
    word_t               hm [MAP_ROWS][MAP_ROWS];
    logic signed [127:0] acc;
    logic signed [127:0] prod_wide;
    word_t               prod;
    logic                sat;
    hess_out_t           r;
    hm[0][0] = hs[0];
    hm[0][1] = hs[1];
    hm[1][0] = hs[1];
    hm[1][1] = hs[2];
    hm[0][2] = hs[3];
    hm[2][0] = hs[3];
    hm[1][2] = hs[4];
    hm[2][1] = hs[4];
    hm[2][2] = hs[5];
    sat = 1'b0;
    for (int n = 0; n < OUT_COUNT; n++) begin
      acc = '0;
      for (int k = 0; k < int'(dim_model); k++) begin
        for (int l = 0; l < int'(dim_model); l++) begin
          prod_wide = inv_map[k][POS_I[n]] * inv_map[l][POS_J[n]];
          prod = clip_word((prod_wide + ROUND_HALF) >>> FRAC_BITS, sat);
          acc = acc + hm[k][l] * prod;
        end
      end
      r.v[n] = (dim_model == 2'd0) ? 32'd0 : clip_word((acc + ROUND_HALF) >>> FRAC_BITS, sat);
    end
    r.sat = sat;
    return r;
  endfunction

  function automatic word_t pick_word(input spread_e spread);
    int signed v;
    case (spread)
      SPREAD_FULL: v = $urandom;
      SPREAD_UNIT: v = $signed($urandom_range(0, 262143)) - 131072;
      SPREAD_WIDE: v = $signed($urandom_range(0, 16777215)) - 8388608;
      default: begin
        case ($urandom_range(0, 5))
          0: v = WORD_MAX;
          1: v = WORD_MIN;
          2: v = 0;
          3: v = ONE;
          4: v = -ONE;
          default: v = -1;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic spread_e pick_spread();
    case ($urandom_range(0, 9))
      0: return SPREAD_FULL;
      1: return SPREAD_EDGE;
      2, 3: return SPREAD_WIDE;
      default: return SPREAD_UNIT;
    endcase
  endfunction

  function automatic hess_vec_t random_hessian(input spread_e spread);
    hess_vec_t hs;
    for (int n = 0; n < OUT_COUNT; n++) hs[n] = pick_word(spread);
    return hs;
  endfunction

  task automatic send_item(input logic op, input logic [1:0] row, input word_t dx, input word_t dy,
                           input word_t dz, input hess_vec_t hs);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= {6'd0, hs[5], hs[4], hs[3], hs[2], hs[1], hs[0], dz, dy, dx, row};
    s_axis_tuser <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    if (op == OP_LOAD) begin
      if (row <= ROW_ZETA) begin
        inv_map[row][0] = dx;
        inv_map[row][1] = dy;
        inv_map[row][2] = dz;
      end
    end else begin
      pending_hessians.push_back(physical_hessian(hs));
    end
  endtask

  task automatic send_random_load(input logic [1:0] row);
    spread_e spread;
    spread = pick_spread();
    send_item(OP_LOAD, row, pick_word(spread), pick_word(spread), pick_word(spread),
              random_hessian(SPREAD_FULL));
  endtask

  task automatic send_random_transform();
    send_item(OP_XFORM, 2'($urandom_range(0, 3)), pick_word(SPREAD_FULL), pick_word(SPREAD_FULL),
              pick_word(SPREAD_FULL), random_hessian(pick_spread()));
  endtask

  // Drop valid, wait for every result, then let the pipeline settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_hessians.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_element_dim(input logic [1:0] dim);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= dim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dim_model = dim;
  endtask

  task automatic load_identity();
    send_item(OP_LOAD, ROW_XI, ONE, 32'sd0, 32'sd0, '0);
    send_item(OP_LOAD, ROW_ETA, 32'sd0, ONE, 32'sd0, '0);
    send_item(OP_LOAD, ROW_ZETA, 32'sd0, 32'sd0, ONE, '0);
  endtask

  task automatic test_map_loads();
    load_identity();
    send_item(OP_LOAD, 2'd3, WORD_MAX, WORD_MIN, WORD_MAX, '1);
    send_item(OP_XFORM, ROW_XI, 32'sd0, 32'sd0, 32'sd0,
              {32'h0006_0000, 32'h0005_0000, 32'h0004_0000,
               32'h0003_0000, 32'h0002_0000, 32'h0001_0000});
  endtask

  task automatic test_extreme_values();
    send_item(OP_XFORM, ROW_XI, 32'sd0, 32'sd0, 32'sd0, '0);
    send_item(OP_XFORM, ROW_XI, 32'sd0, 32'sd0, 32'sd0, {OUT_COUNT{WORD_MAX}});
    send_item(OP_XFORM, ROW_XI, 32'sd0, 32'sd0, 32'sd0, {OUT_COUNT{WORD_MIN}});
    send_item(OP_LOAD, ROW_XI, WORD_MIN, WORD_MAX, -32'sd1, '0);
    send_item(OP_LOAD, ROW_ETA, WORD_MAX, WORD_MIN, 32'sd1, '0);
    send_item(OP_LOAD, ROW_ZETA, 32'sd0, WORD_MIN, WORD_MAX, '0);
    send_item(OP_XFORM, ROW_XI, 32'sd0, 32'sd0, 32'sd0, {OUT_COUNT{WORD_MAX}});
    send_item(OP_XFORM, ROW_XI, 32'sd0, 32'sd0, 32'sd0,
              {WORD_MIN, WORD_MAX, -32'sd1, 32'sd1, WORD_MAX, WORD_MIN});
    load_identity();
  endtask

  task automatic test_element_dims();
    for (int d = 0; d <= 3; d++) begin
      set_element_dim(2'(d));
      send_item(OP_XFORM, ROW_XI, 32'sd0, 32'sd0, 32'sd0, random_hessian(SPREAD_UNIT));
      send_item(OP_XFORM, ROW_XI, 32'sd0, 32'sd0, 32'sd0, random_hessian(SPREAD_EDGE));
    end
  endtask

  task automatic test_random_stream();
    logic [1:0]  dims [5] = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3};
    int unsigned sent;
    int unsigned loads;
    int unsigned xforms;
    bit          paused;
    foreach (dims[p]) begin
      set_element_dim(dims[p]);
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 5) == 0) send_burst = !send_burst;
        if ($urandom_range(0, 9) == 0) send_random_load(2'd3);
        loads = $urandom_range(0, 3);
        repeat (loads) send_random_load(2'($urandom_range(0, 2)));
        xforms = $urandom_range(1, 8);
        repeat (xforms) send_random_transform();
        sent += loads + xforms;
        if (!paused && sent > PHASE_ITEMS / 2) begin
          paused = 1'b1;
          drain();
        end
      end
    end
  endtask

  initial begin : result_checker
    hess_out_t   want;
    hess_vec_t   got;
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = recv_burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      got = m_axis_tdata;
      if (pending_hessians.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: %h", got));
      end else begin
        want = pending_hessians.pop_front();
        for (int n = 0; n < OUT_COUNT; n++) begin
          if (got[n] !== want.v[n])
            flag_mismatch($sformatf("%s got %h want %h", FIELD_NAMES[n], got[n], want.v[n]));
        end
        if (m_axis_tuser !== want.sat)
          flag_mismatch($sformatf("saturated got %b want %b", m_axis_tuser, want.sat));
      end
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    foreach (inv_map[r, c]) inv_map[r][c] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_map_loads();
    test_extreme_values();
    test_element_dims();
    test_random_stream();
    drain();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
